FILE: hw/rtl/lpps_pkg.sv
// Shared types, codes and helpers of the lamp profile power cycle sequencer.
package lpps_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [1:0] t_prof;

    typedef enum logic [1:0] {
        CMD_POLL      = 2'd0,
        CMD_ACK       = 2'd1,
        CMD_RESET_UNK = 2'd2,
        CMD_REQUEST   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OFF          = 3'd0,
        ST_RETRY        = 3'd1,
        ST_CYCLE_OFF    = 3'd2,
        ST_RESET_OFF    = 3'd3,
        ST_RESET_SETTLE = 3'd4,
        ST_CYCLE_SETTLE = 3'd5,
        ST_STABLE       = 3'd6
    } t_stage;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_OFF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_OFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_SETTLE   = 3'd4;

    localparam t_time RST_CYCLE_OFF   = 32'd1000;
    localparam t_time RST_TOGGLE_MAX  = 32'd5000;
    localparam t_time RST_RESET_OFF   = 32'd10000;
    localparam t_time RST_RETRY_DELAY = 32'd2000;
    localparam t_time RST_ON_SETTLE   = 32'd1000;

    localparam t_prof PROF_DAY   = 2'd0;
    localparam t_prof PROF_NIGHT = 2'd2;
    localparam t_prof PROF_BAD   = 2'd3;

    typedef struct packed {
        t_time cycle_off;
        t_time toggle_max;
        t_time reset_off;
        t_time retry_delay;
        t_time on_settle;
    } t_cfg;

    typedef struct packed {
        t_cmd  cmd;
        t_time now_time;
        logic  write_ok;
        logic  want_on;
        t_prof want_profile;
    } t_item;

    typedef struct packed {
        logic   write_needed;
        logic   relay_command;
        logic   relay_level;
        logic   prof_known;
        logic   off_timing;
        logic   write_pending;
        logic   desired_lit;
        t_prof  active_prof;
        t_prof  desired_prof;
        t_stage stage;
        t_time  now_time;
        t_time  deadline;
        t_time  off_start;
    } t_snap;

    typedef struct packed {
        logic   write_needed;
        logic   relay_command;
        logic   relay_is_on;
        logic   profile_known;
        logic   busy_res;
        t_prof  current_profile;
        t_prof  target_profile;
        t_stage stage_code;
    } t_result;

    // true once now has reached or passed when, modulo 2^32
    function automatic logic f_reached(input t_time now, input t_time when);
        t_time diff;
        diff = now - when;
        return ~diff[TIME_W-1];
    endfunction

endpackage

FILE: hw/rtl/lpps_core.sv
// Input word register and single-pass sequencer state update.
module lpps_core
    import lpps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output logic  o_snap_valid,
    input  logic  i_snap_ready,
    output t_snap o_snap
);

    logic   r_in_valid;
    t_item  r_item;

    logic   r_desired_lit, r_relay_level, r_prof_known, r_off_timing;
    logic   r_reset_baseline, r_write_pending, r_pending_level;
    t_prof  r_desired_prof, r_active_prof;
    t_stage r_stage;
    t_time  r_deadline, r_off_start;

    logic   n_desired_lit, n_relay_level, n_prof_known, n_off_timing;
    logic   n_reset_baseline, n_write_pending, n_pending_level;
    t_prof  n_desired_prof, n_active_prof;
    t_stage n_stage;
    t_time  n_deadline, n_off_start;
    logic   need, lvl;

    logic   fire;

    assign o_in_ready   = !r_in_valid || i_snap_ready;
    assign fire         = r_in_valid && i_snap_ready;
    assign o_snap_valid = r_in_valid;

    always_comb begin
        logic  done;
        t_time now;
        t_time elapsed;
        now              = r_item.now_time;
        done             = 1'b0;
        elapsed          = '0;
        need             = 1'b0;
        lvl              = 1'b0;
        n_desired_lit    = r_desired_lit;
        n_desired_prof   = r_desired_prof;
        n_relay_level    = r_relay_level;
        n_prof_known     = r_prof_known;
        n_active_prof    = r_active_prof;
        n_stage          = r_stage;
        n_deadline       = r_deadline;
        n_off_start      = r_off_start;
        n_off_timing     = r_off_timing;
        n_reset_baseline = r_reset_baseline;
        n_write_pending  = r_write_pending;
        n_pending_level  = r_pending_level;

        case (r_item.cmd)
            CMD_POLL: begin
                if (r_write_pending) begin
                    need = 1'b1;
                    lvl  = r_pending_level;
                end else if (!r_desired_lit) begin
                    if (r_relay_level) begin
                        n_write_pending = 1'b1;
                        n_pending_level = 1'b0;
                        need            = 1'b1;
                    end else begin
                        if (!r_off_timing) begin
                            n_off_start  = now;
                            n_off_timing = 1'b1;
                        end
                        elapsed = now - n_off_start;
                        if (r_prof_known && elapsed > i_cfg.toggle_max) begin
                            n_prof_known     = 1'b0;
                            n_reset_baseline = 1'b1;
                        end
                        n_stage = ST_OFF;
                    end
                end else begin
                    if (r_stage == ST_RETRY) begin
                        if (!f_reached(now, r_deadline)) begin
                            lvl  = r_relay_level;
                            done = 1'b1;
                        end else begin
                            n_stage = r_prof_known ? ST_STABLE : ST_RESET_OFF;
                        end
                    end
                    if (!done && n_stage == ST_OFF && !r_relay_level && r_prof_known) begin
                        done    = 1'b1;
                        elapsed = now - r_off_start;
                        if (elapsed <= i_cfg.toggle_max) begin
                            n_stage    = ST_CYCLE_OFF;
                            n_deadline = r_off_start + i_cfg.cycle_off;
                            if (f_reached(now, n_deadline)) begin
                                n_write_pending = 1'b1;
                                n_pending_level = 1'b1;
                                need            = 1'b1;
                                lvl             = 1'b1;
                            end
                        end else begin
                            n_prof_known     = 1'b0;
                            n_reset_baseline = 1'b1;
                            n_stage          = ST_RESET_OFF;
                            n_write_pending  = 1'b1;
                            n_pending_level  = 1'b1;
                            need             = 1'b1;
                            lvl              = 1'b1;
                        end
                    end
                    if (!done && !r_prof_known) begin
                        done    = 1'b1;
                        n_stage = ST_RESET_OFF;
                        if (r_relay_level) begin
                            n_write_pending = 1'b1;
                            n_pending_level = 1'b0;
                            need            = 1'b1;
                        end else if (r_reset_baseline) begin
                            n_write_pending = 1'b1;
                            n_pending_level = 1'b1;
                            need            = 1'b1;
                            lvl             = 1'b1;
                        end else if (!r_off_timing) begin
                            n_off_start  = now;
                            n_off_timing = 1'b1;
                        end else begin
                            elapsed = now - r_off_start;
                            if (elapsed >= i_cfg.reset_off) begin
                                n_write_pending = 1'b1;
                                n_pending_level = 1'b1;
                                need            = 1'b1;
                                lvl             = 1'b1;
                            end
                        end
                    end
                    if (!done && (n_stage == ST_RESET_SETTLE || n_stage == ST_CYCLE_SETTLE))
                    begin
                        if (!f_reached(now, r_deadline)) begin
                            lvl  = r_relay_level;
                            done = 1'b1;
                        end else begin
                            n_stage = ST_STABLE;
                        end
                    end
                    if (!done && n_stage == ST_CYCLE_OFF) begin
                        done = 1'b1;
                        if (f_reached(now, r_deadline)) begin
                            n_write_pending = 1'b1;
                            n_pending_level = 1'b1;
                            need            = 1'b1;
                            lvl             = 1'b1;
                        end
                    end
                    if (!done) begin
                        if (r_active_prof == r_desired_prof) begin
                            n_stage = ST_STABLE;
                            lvl     = r_relay_level;
                        end else begin
                            n_stage         = ST_CYCLE_OFF;
                            n_write_pending = 1'b1;
                            n_pending_level = 1'b0;
                            need            = 1'b1;
                        end
                    end
                end
            end
            CMD_ACK: begin
                if (r_write_pending) begin
                    n_write_pending = 1'b0;
                    if (!r_item.write_ok) begin
                        n_prof_known = 1'b0;
                        n_stage      = ST_RETRY;
                        n_deadline   = now + i_cfg.retry_delay;
                    end else begin
                        n_relay_level = r_pending_level;
                        if (!r_pending_level) begin
                            n_off_start  = now;
                            n_off_timing = 1'b1;
                            if (!r_desired_lit) begin
                                n_stage = ST_OFF;
                            end else if (r_prof_known) begin
                                n_stage    = ST_CYCLE_OFF;
                                n_deadline = now + i_cfg.cycle_off;
                            end else begin
                                n_stage    = ST_RESET_OFF;
                                n_deadline = now + i_cfg.reset_off;
                            end
                        end else begin
                            n_off_start      = '0;
                            n_off_timing     = 1'b0;
                            n_reset_baseline = 1'b0;
                            if (!r_prof_known) begin
                                n_active_prof = PROF_DAY;
                                n_prof_known  = 1'b1;
                                n_stage       = ST_RESET_SETTLE;
                                n_deadline    = now + i_cfg.on_settle;
                            end else if (r_stage == ST_CYCLE_OFF) begin
                                n_active_prof = (r_active_prof >= PROF_NIGHT) ?
                                                PROF_DAY : r_active_prof + 2'd1;
                                n_stage       = ST_CYCLE_SETTLE;
                                n_deadline    = now + i_cfg.on_settle;
                            end else begin
                                n_prof_known = 1'b0;
                                n_stage      = ST_RESET_OFF;
                            end
                        end
                    end
                end
            end
            CMD_RESET_UNK: begin
                n_prof_known     = 1'b0;
                n_relay_level    = 1'b0;
                n_stage          = ST_OFF;
                n_deadline       = '0;
                n_off_start      = now;
                n_off_timing     = 1'b1;
                n_reset_baseline = 1'b0;
                n_write_pending  = 1'b0;
            end
            CMD_REQUEST: begin
                n_desired_lit  = r_item.want_on;
                n_desired_prof = (r_item.want_profile == PROF_BAD) ?
                                 PROF_DAY : r_item.want_profile;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_snap.write_needed  = need;
        o_snap.relay_command = lvl;
        o_snap.relay_level   = n_relay_level;
        o_snap.prof_known    = n_prof_known;
        o_snap.off_timing    = n_off_timing;
        o_snap.write_pending = n_write_pending;
        o_snap.desired_lit   = n_desired_lit;
        o_snap.active_prof   = n_active_prof;
        o_snap.desired_prof  = n_desired_prof;
        o_snap.stage         = n_stage;
        o_snap.now_time      = r_item.now_time;
        o_snap.deadline      = n_deadline;
        o_snap.off_start     = n_off_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_desired_lit    <= 1'b0;
            r_desired_prof   <= PROF_DAY;
            r_relay_level    <= 1'b0;
            r_prof_known     <= 1'b0;
            r_active_prof    <= PROF_DAY;
            r_stage          <= ST_OFF;
            r_deadline       <= '0;
            r_off_start      <= '0;
            r_off_timing     <= 1'b0;
            r_reset_baseline <= 1'b0;
            r_write_pending  <= 1'b0;
            r_pending_level  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_desired_lit    <= n_desired_lit;
                r_desired_prof   <= n_desired_prof;
                r_relay_level    <= n_relay_level;
                r_prof_known     <= n_prof_known;
                r_active_prof    <= n_active_prof;
                r_stage          <= n_stage;
                r_deadline       <= n_deadline;
                r_off_start      <= n_off_start;
                r_off_timing     <= n_off_timing;
                r_reset_baseline <= n_reset_baseline;
                r_write_pending  <= n_write_pending;
                r_pending_level  <= n_pending_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_item;
        end
    end

    a_prof_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active_prof != PROF_BAD && r_desired_prof != PROF_BAD)
        else $error("profile register holds an invalid code");

    a_reset_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_item.cmd == CMD_RESET_UNK |=>
            !r_write_pending && !r_prof_known && !r_relay_level && r_off_timing)
        else $error("reset to unknown left stale state");

    a_stray_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_item.cmd == CMD_ACK && !r_write_pending |=>
            $stable(r_stage) && $stable(r_deadline) && $stable(r_relay_level))
        else $error("acknowledge without pending write changed state");

    a_repoll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_item.cmd == CMD_POLL && r_write_pending |=>
            r_write_pending && $stable(r_pending_level) && $stable(r_stage))
        else $error("poll with pending write changed state");

endmodule

FILE: hw/rtl/lpps_report.sv
// Snapshot register, status evaluation and result word register.
module lpps_report
    import lpps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_snap_valid,
    output logic    o_snap_ready,
    input  t_snap   i_snap,
    input  t_time   i_toggle_max,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    logic    r_snap_valid;
    t_snap   r_snap;
    logic    r_out_valid;
    t_result r_result;

    logic    out_free;
    logic    snap_move;
    logic    timer_busy;
    logic    known_rep;
    logic    busy;
    t_time   off_elapsed;
    t_result n_result;

    assign out_free     = !r_out_valid || i_out_ready;
    assign snap_move    = r_snap_valid && out_free;
    assign o_snap_ready = !r_snap_valid || out_free;

    assign off_elapsed = r_snap.now_time - r_snap.off_start;
    assign timer_busy  = (r_snap.stage >= ST_RETRY) && (r_snap.stage <= ST_CYCLE_SETTLE) &&
                         !f_reached(r_snap.now_time, r_snap.deadline);
    assign known_rep   = r_snap.prof_known &&
                         (r_snap.relay_level || !r_snap.off_timing ||
                          off_elapsed <= i_toggle_max);
    assign busy        = r_snap.write_pending || timer_busy ||
                         (r_snap.desired_lit &&
                          (!r_snap.prof_known || r_snap.active_prof != r_snap.desired_prof ||
                           r_snap.stage != ST_STABLE));

    always_comb begin
        n_result.write_needed    = r_snap.write_needed;
        n_result.relay_command   = r_snap.relay_command;
        n_result.relay_is_on     = r_snap.relay_level;
        n_result.profile_known   = known_rep;
        n_result.busy_res        = busy;
        n_result.current_profile = r_snap.active_prof;
        n_result.target_profile  = r_snap.desired_prof;
        n_result.stage_code      = r_snap.stage;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_snap_ready) begin
                r_snap_valid <= i_snap_valid;
            end
            if (out_free) begin
                r_out_valid <= r_snap_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_ready && i_snap_valid) begin
            r_snap <= i_snap;
        end
        if (snap_move) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

FILE: hw/rtl/lamp_profile_power_cycle_sequencer_unit.sv
// Top level of the lamp profile power cycle sequencer: ports, config registers, stages.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+-----------------------------------
//  input   | in        | i_in_valid / o_in_ready | cmd, now_time, write_ok, want_*
//  output  | out       | o_out_valid/i_out_ready | relay decision and status snapshot
//  config  | in        | i_cfg_valid/o_cfg_ready | 3-bit register index, 32-bit data
//
//  One word per cycle sustained while the output is not stalled; each word passes three
//  registers: input register, state update into the snapshot register, status compare
//  into the result register, from which the result is offered. Synchronous active-low
//  reset returns the sequencer state, valid flags and config registers to their defaults.
//  A stalled output holds the result and back-pressures stage by stage; config
//  writes are always taken.
module lamp_profile_power_cycle_sequencer_unit
    import lpps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_cmd,
    input  logic [TIME_W-1:0]    i_now_time,
    input  logic                 i_write_ok,
    input  logic                 i_want_on,
    input  logic [1:0]           i_want_profile,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_write_needed,
    output logic                 o_relay_command,
    output logic                 o_relay_is_on,
    output logic                 o_profile_known,
    output logic                 o_busy_res,
    output logic [1:0]           o_current_profile,
    output logic [1:0]           o_target_profile,
    output logic [2:0]           o_stage_code,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data
);

    t_cfg    r_cfg;
    t_item   item;
    logic    snap_valid;
    logic    snap_ready;
    t_snap   snap;
    t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cycle_off   <= RST_CYCLE_OFF;
            r_cfg.toggle_max  <= RST_TOGGLE_MAX;
            r_cfg.reset_off   <= RST_RESET_OFF;
            r_cfg.retry_delay <= RST_RETRY_DELAY;
            r_cfg.on_settle   <= RST_ON_SETTLE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CYCLE_OFF:   r_cfg.cycle_off   <= i_cfg_data;
                CFG_TOGGLE_MAX:  r_cfg.toggle_max  <= i_cfg_data;
                CFG_RESET_OFF:   r_cfg.reset_off   <= i_cfg_data;
                CFG_RETRY_DELAY: r_cfg.retry_delay <= i_cfg_data;
                CFG_ON_SETTLE:   r_cfg.on_settle   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        item.cmd          = t_cmd'(i_cmd);
        item.now_time     = i_now_time;
        item.write_ok     = i_write_ok;
        item.want_on      = i_want_on;
        item.want_profile = i_want_profile;
    end

    lpps_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_item       (item),
        .i_cfg        (r_cfg),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    lpps_report u_report (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .i_toggle_max (r_cfg.toggle_max),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (result)
    );

    assign o_write_needed    = result.write_needed;
    assign o_relay_command   = result.relay_command;
    assign o_relay_is_on     = result.relay_is_on;
    assign o_profile_known   = result.profile_known;
    assign o_busy_res        = result.busy_res;
    assign o_current_profile = result.current_profile;
    assign o_target_profile  = result.target_profile;
    assign o_stage_code      = result.stage_code;

endmodule

FILE: tb/lamp_profile_power_cycle_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the lamp profile power cycle sequencer unit.
module lamp_profile_power_cycle_sequencer_unit_tb;
    import lpps_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned STALL_CYCLES = 80;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam t_time ALL_ONES = 32'hFFFF_FFFF;
    localparam t_prof PROF_DAWN = 2'd1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = '0;
    t_time now_time = '0;
    logic write_ok = 1'b0;
    logic want_on = 1'b0;
    logic [1:0] want_profile = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic write_needed;
    logic relay_command;
    logic relay_is_on;
    logic profile_known;
    logic busy_res;
    logic [1:0] current_profile;
    logic [1:0] target_profile;
    logic [2:0] stage_code;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    t_time cfg_data = '0;

    // lamp state as the block should hold it
    t_cfg timing;
    logic lit_wanted, relay_up, prof_sure, dark_timed, force_day, wr_busy, wr_level;
    t_prof prof_wanted, cur_prof;
    t_stage stage;
    t_time due_time, dark_since;

    t_result lamp_expect[$];
    t_time clock_ms;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 18;
    int unsigned recv_idle_pct = 85;
    logic stall_req = 1'b0;
    logic hold_active = 1'b0;

    lamp_profile_power_cycle_sequencer_unit i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_cmd            (cmd),
        .i_now_time       (now_time),
        .i_write_ok       (write_ok),
        .i_want_on        (want_on),
        .i_want_profile   (want_profile),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_write_needed   (write_needed),
        .o_relay_command  (relay_command),
        .o_relay_is_on    (relay_is_on),
        .o_profile_known  (profile_known),
        .o_busy_res       (busy_res),
        .o_current_profile(current_profile),
        .o_target_profile (target_profile),
        .o_stage_code     (stage_code),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic time_passed(input t_time now, input t_time when);
        return $signed(now - when) >= 0;
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic t_time pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, 700);
        if (r < 85) return $urandom_range(700, 3000);
        if (r < 97) return $urandom_range(3000, 15000);
        return $urandom();
    endfunction

    task automatic lamp_reset();
        timing.cycle_off = RST_CYCLE_OFF;
        timing.toggle_max = RST_TOGGLE_MAX;
        timing.reset_off = RST_RESET_OFF;
        timing.retry_delay = RST_RETRY_DELAY;
        timing.on_settle = RST_ON_SETTLE;
        lit_wanted = 1'b0;
        prof_wanted = PROF_DAY;
        relay_up = 1'b0;
        prof_sure = 1'b0;
        cur_prof = PROF_DAY;
        stage = ST_OFF;
        due_time = '0;
        dark_since = '0;
        dark_timed = 1'b0;
        force_day = 1'b0;
        wr_busy = 1'b0;
        wr_level = 1'b0;
    endtask

    task automatic set_lamp_reg(input logic [CFG_IDX_W-1:0] idx, input t_time data);
        case (idx)
            CFG_CYCLE_OFF:   timing.cycle_off = data;
            CFG_TOGGLE_MAX:  timing.toggle_max = data;
            CFG_RESET_OFF:   timing.reset_off = data;
            CFG_RETRY_DELAY: timing.retry_delay = data;
            CFG_ON_SETTLE:   timing.on_settle = data;
            default: ;
        endcase
    endtask

    task automatic start_write(input logic level, output logic need, output logic lvl);
        wr_busy = 1'b1;
        wr_level = level;
        need = 1'b1;
        lvl = level;
    endtask

    task automatic poll_lamp(input t_time now, output logic need, output logic lvl);
        need = 1'b0;
        lvl = 1'b0;
        if (wr_busy) begin
            need = 1'b1;
            lvl = wr_level;
            return;
        end
        if (!lit_wanted) begin
            if (relay_up) begin
                start_write(1'b0, need, lvl);
                return;
            end
            if (!dark_timed) begin
                dark_since = now;
                dark_timed = 1'b1;
            end
            if (prof_sure && now - dark_since > timing.toggle_max) begin
                prof_sure = 1'b0;
                force_day = 1'b1;
            end
            stage = ST_OFF;
            return;
        end
        if (stage == ST_RETRY) begin
            if (!time_passed(now, due_time)) begin
                lvl = relay_up;
                return;
            end
            stage = prof_sure ? ST_STABLE : ST_RESET_OFF;
        end
        if (stage == ST_OFF && !relay_up && prof_sure) begin
            if (now - dark_since <= timing.toggle_max) begin
                stage = ST_CYCLE_OFF;
                due_time = dark_since + timing.cycle_off;
                if (time_passed(now, due_time)) start_write(1'b1, need, lvl);
                return;
            end
            prof_sure = 1'b0;
            force_day = 1'b1;
            stage = ST_RESET_OFF;
            start_write(1'b1, need, lvl);
            return;
        end
        if (!prof_sure) begin
            stage = ST_RESET_OFF;
            if (relay_up) begin
                start_write(1'b0, need, lvl);
                return;
            end
            if (force_day) begin
                start_write(1'b1, need, lvl);
                return;
            end
            if (!dark_timed) begin
                dark_since = now;
                dark_timed = 1'b1;
                return;
            end
            if (now - dark_since >= timing.reset_off) start_write(1'b1, need, lvl);
            return;
        end
        if (stage == ST_RESET_SETTLE || stage == ST_CYCLE_SETTLE) begin
            if (!time_passed(now, due_time)) begin
                lvl = relay_up;
                return;
            end
            stage = ST_STABLE;
        end
        if (stage == ST_CYCLE_OFF) begin
            if (time_passed(now, due_time)) start_write(1'b1, need, lvl);
            return;
        end
        if (cur_prof == prof_wanted) begin
            stage = ST_STABLE;
            lvl = relay_up;
            return;
        end
        stage = ST_CYCLE_OFF;
        start_write(1'b0, need, lvl);
    endtask

    task automatic ack_lamp(input logic ok, input t_time now);
        logic level;
        if (!wr_busy) return;
        level = wr_level;
        wr_busy = 1'b0;
        if (!ok) begin
            prof_sure = 1'b0;
            stage = ST_RETRY;
            due_time = now + timing.retry_delay;
            return;
        end
        relay_up = level;
        if (!level) begin
            dark_since = now;
            dark_timed = 1'b1;
            if (!lit_wanted) begin
                stage = ST_OFF;
            end else if (prof_sure) begin
                stage = ST_CYCLE_OFF;
                due_time = now + timing.cycle_off;
            end else begin
                stage = ST_RESET_OFF;
                due_time = now + timing.reset_off;
            end
            return;
        end
        dark_since = '0;
        dark_timed = 1'b0;
        force_day = 1'b0;
        if (!prof_sure) begin
            cur_prof = PROF_DAY;
            prof_sure = 1'b1;
            stage = ST_RESET_SETTLE;
        end else if (stage == ST_CYCLE_OFF) begin
            cur_prof = (cur_prof == PROF_NIGHT) ? PROF_DAY : cur_prof + 2'd1;
            stage = ST_CYCLE_SETTLE;
        end else begin
            prof_sure = 1'b0;
            stage = ST_RESET_OFF;
            return;
        end
        due_time = now + timing.on_settle;
    endtask

    task automatic lamp_step(input t_item w, output t_result r);
        logic need, lvl, timer_run;
        need = 1'b0;
        lvl = 1'b0;
        case (w.cmd)
            CMD_POLL: poll_lamp(w.now_time, need, lvl);
            CMD_ACK:  ack_lamp(w.write_ok, w.now_time);
            CMD_RESET_UNK: begin
                prof_sure = 1'b0;
                relay_up = 1'b0;
                stage = ST_OFF;
                due_time = '0;
                dark_since = w.now_time;
                dark_timed = 1'b1;
                force_day = 1'b0;
                wr_busy = 1'b0;
            end
            CMD_REQUEST: begin
                lit_wanted = w.want_on;
                prof_wanted = (w.want_profile == PROF_BAD) ? PROF_DAY : w.want_profile;
            end
            default: ;
        endcase
        timer_run = stage >= ST_RETRY && stage <= ST_CYCLE_SETTLE &&
                    !time_passed(w.now_time, due_time);
        r.write_needed = need;
        r.relay_command = lvl;
        r.relay_is_on = relay_up;
        r.profile_known = prof_sure && (relay_up || !dark_timed ||
                          w.now_time - dark_since <= timing.toggle_max);
        r.busy_res = wr_busy || timer_run || (lit_wanted && (!prof_sure ||
                     cur_prof != prof_wanted || stage != ST_STABLE));
        r.current_profile = cur_prof;
        r.target_profile = prof_wanted;
        r.stage_code = stage;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (lamp_expect.size() == 0) begin
                $error("result word with no expectation waiting");
                fail_count++;
            end else begin
                want = lamp_expect.pop_front();
                check_field("write_needed", 32'(want.write_needed), 32'(write_needed));
                check_field("relay_command", 32'(want.relay_command), 32'(relay_command));
                check_field("relay_is_on", 32'(want.relay_is_on), 32'(relay_is_on));
                check_field("profile_known", 32'(want.profile_known), 32'(profile_known));
                check_field("busy_res", 32'(want.busy_res), 32'(busy_res));
                check_field("current_profile", 32'(want.current_profile),
                            32'(current_profile));
                check_field("target_profile", 32'(want.target_profile),
                            32'(target_profile));
                check_field("stage_code", 32'(want.stage_code), 32'(stage_code));
            end
        end
    end

    always @(negedge clk) out_ready <= !hold_active && ($urandom_range(0, 99) >= recv_idle_pct);

    initial begin
        forever begin
            wait (stall_req);
            hold_active = 1'b1;
            repeat (STALL_CYCLES) @(posedge clk);
            hold_active = 1'b0;
            stall_req = 1'b0;
        end
    end

    task automatic send_word(input t_item w);
        t_result exp_res;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= w.cmd;
        now_time <= w.now_time;
        write_ok <= w.write_ok;
        want_on <= w.want_on;
        want_profile <= w.want_profile;
        do @(posedge clk); while (!in_ready);
        lamp_step(w, exp_res);
        lamp_expect.push_back(exp_res);
    endtask

    task automatic fire(input t_cmd op, input t_time gap, input logic ok, input logic on,
                        input t_prof prof);
        t_item w;
        clock_ms = clock_ms + gap;
        w.cmd = op;
        w.now_time = clock_ms;
        w.write_ok = ok;
        w.want_on = on;
        w.want_profile = prof;
        send_word(w);
    endtask

    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (lamp_expect.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input t_time data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        set_lamp_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_timings(input t_time c_off, input t_time t_max, input t_time r_off,
                                 input t_time r_dly, input t_time s_on);
        cfg_write(CFG_CYCLE_OFF, c_off);
        cfg_write(CFG_TOGGLE_MAX, t_max);
        cfg_write(CFG_RESET_OFF, r_off);
        cfg_write(CFG_RETRY_DELAY, r_dly);
        cfg_write(CFG_ON_SETTLE, s_on);
    endtask

    task automatic test_directed_walk();
        fire(CMD_POLL, 0, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_ACK, 1, 1'b1, 1'b0, PROF_DAY);
        fire(CMD_REQUEST, 5, 1'b0, 1'b1, PROF_BAD);
        fire(CMD_POLL, 10, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_POLL, 10000, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_POLL, 3, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_ACK, 5, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_POLL, 500, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_POLL, 2000, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_ACK, 5, 1'b1, 1'b0, PROF_DAY);
        fire(CMD_REQUEST, 100, 1'b0, 1'b1, PROF_NIGHT);
        fire(CMD_POLL, 100, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_POLL, 1000, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_ACK, 5, 1'b1, 1'b0, PROF_DAY);
        fire(CMD_POLL, 200, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_POLL, 1000, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_ACK, 5, 1'b1, 1'b0, PROF_DAY);
        fire(CMD_POLL, 1200, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_ACK, 5, 1'b1, 1'b0, PROF_DAY);
        fire(CMD_POLL, 1100, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_ACK, 5, 1'b1, 1'b0, PROF_DAY);
        fire(CMD_POLL, 1500, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_REQUEST, 10, 1'b0, 1'b0, PROF_DAWN);
        fire(CMD_POLL, 10, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_ACK, 5, 1'b1, 1'b0, PROF_DAY);
        fire(CMD_POLL, 6000, 1'b0, 1'b0, PROF_DAY);
        fire(CMD_RESET_UNK, 10, 1'b0, 1'b0, PROF_DAY);
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (wr_busy && pick >= 30)
                fire(CMD_ACK, pick_gap(), $urandom_range(0, 9) != 0, rand_bit(),
                     t_prof'($urandom_range(0, 3)));
            else if (pick < 8)
                fire(CMD_REQUEST, pick_gap(), rand_bit(), $urandom_range(0, 3) != 0,
                     t_prof'($urandom_range(0, 3)));
            else if (pick < 11)
                fire(CMD_RESET_UNK, pick_gap(), rand_bit(), rand_bit(),
                     t_prof'($urandom_range(0, 3)));
            else if (pick < 14)
                fire(CMD_ACK, pick_gap(), rand_bit(), rand_bit(),
                     t_prof'($urandom_range(0, 3)));
            else
                fire(CMD_POLL, pick_gap(), rand_bit(), rand_bit(),
                     t_prof'($urandom_range(0, 3)));
        end
    endtask

    task automatic test_zero_timings();
        drain_block();
        write_timings('0, '0, '0, '0, '0);
        cfg_write(CFG_SPARE_LO, $urandom());
        test_random_traffic(90);
    endtask

    task automatic test_max_timings();
        drain_block();
        write_timings(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        cfg_write(CFG_SPARE_HI, $urandom());
        test_random_traffic(90);
    endtask

    task automatic test_output_stall();
        drain_block();
        stall_req = 1'b1;
        test_random_traffic(30);
    endtask

    task automatic test_mixed_timings();
        drain_block();
        write_timings($urandom_range(0, 3000), $urandom_range(0, 8000),
                      $urandom_range(0, 15000), $urandom_range(0, 4000),
                      $urandom_range(0, 3000));
        test_random_traffic(90);
    endtask

    initial begin
        lamp_reset();
        clock_ms = ALL_ONES;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_walk();
        test_random_traffic(130);
        test_zero_timings();
        send_idle_pct = 85;
        recv_idle_pct = 18;
        test_max_timings();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_stall();
        test_mixed_timings();
        drain_block();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
